// ----- rtl/epoch_to_calendar_date_time_unit_assert.svh -----
// assertion macros shared by the calendar conversion modules
`ifndef EPOCH_TO_CALENDAR_DATE_TIME_UNIT_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_TIME_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define E2CAL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define E2CAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/e2cal_pkg.sv -----
// types, constants and calendar functions for the epoch to calendar converter
`timescale 1ns / 1ps

package e2cal_pkg;

   localparam int EpochWidth = 32;
   localparam int DaysWidth  = 16;
   localparam int RemWidth   = 17;
   localparam int YearWidth  = 12;

   localparam logic [RemWidth-1:0]  SecsPerDay  = 17'd86400;
   localparam logic [RemWidth-1:0]  SecsPerHour = 17'd3600;
   localparam logic [RemWidth-1:0]  SecsPerMin  = 17'd60;
   localparam logic [4:0]           HoursPerDay = 5'd24;
   localparam logic [YearWidth-1:0] BaseYear    = 12'd1970;
   localparam logic [YearWidth-1:0] MaxYear     = 12'd2106;
   localparam logic [8:0]           PlainYearDays = 9'd365;
   localparam logic [4:0]           LeapFebDays   = 5'd29;
   localparam logic [3:0]           LastMonth     = 4'd11;
   localparam logic [3:0]           MonthFeb      = 4'd1;

   // reciprocals: ceil(2^35 / 675), ceil(2^21 / 225), ceil(2^14 / 15)
   localparam logic [25:0]          DayRecip  = 26'd50903317;
   localparam logic [13:0]          HourRecip = 14'd9321;
   localparam logic [10:0]          MinRecip  = 11'd1093;

   typedef struct packed {
      logic load;
      logic day_quo;
      logic day_rem;
      logic hour_quo;
      logic hour_rem;
      logic min_quo;
      logic min_rem;
      logic year_step;
      logic start_month;
      logic month_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   // years in range are 1970..2106, so 2100 is the only century that is not leap
   function automatic logic leap_year(input logic [YearWidth-1:0] y);
      logic div4;
      logic century;
      logic div400;
      div4    = (y[1:0] == 2'b00);
      century = (y == 12'd1900) || (y == 12'd2000) || (y == 12'd2100) || (y == 12'd2200);
      div400  = (y == 12'd2000);
      return div4 && (!century || div400);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd0:    len = 5'd31;
         4'd1:    len = 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      if (leap && (m == MonthFeb)) begin
         len = LeapFebDays;
      end
      return len;
   endfunction

endpackage

// ----- rtl/e2cal_dpath.sv -----
// datapath: reciprocal dividers for the time of day, year and month walk, result registers
`timescale 1ns / 1ps
`include "epoch_to_calendar_date_time_unit_assert.svh"

module e2cal_dpath
   import e2cal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic [EpochWidth-1:0] req_epoch_seconds,
   output logic [11:0]           rsp_year,
   output logic [3:0]            rsp_month,
   output logic [4:0]            rsp_day,
   output logic [4:0]            rsp_hour,
   output logic [5:0]            rsp_minute,
   output logic [5:0]            rsp_second
);

   logic [EpochWidth-1:0] epoch_ff, epoch_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [DaysWidth-1:0]  days_ff, days_in;
   logic [YearWidth-1:0]  year_ff, year_in;
   logic [3:0]            mon_ff, mon_in;
   logic [4:0]            hour_ff, hour_in;
   logic [5:0]            minute_ff, minute_in;
   logic [5:0]            second_ff, second_in;
   logic [11:0]           out_year_ff, out_year_in;
   logic [3:0]            out_month_ff, out_month_in;
   logic [4:0]            out_day_ff, out_day_in;
   logic [4:0]            out_hour_ff, out_hour_in;
   logic [5:0]            out_minute_ff, out_minute_in;
   logic [5:0]            out_second_ff, out_second_in;

   logic [50:0]           day_prod;
   logic [32:0]           day_mul;
   logic [26:0]           hour_prod;
   logic [RemWidth-1:0]   hour_mul;
   logic [20:0]           min_prod;
   logic [RemWidth-1:0]   min_mul;
   logic [RemWidth-1:0]   sec_full;
   logic                  leap;
   logic [8:0]            year_len;
   logic [4:0]            month_len;

   // day = (epoch / 128) / 675, hour = (rest / 16) / 225, minute = (rest / 4) / 15
   assign day_prod  = {26'd0, epoch_ff[EpochWidth-1:7]} * {25'd0, DayRecip};
   assign day_mul   = {17'd0, days_ff} * {16'd0, SecsPerDay};
   assign hour_prod = {14'd0, rem_ff[RemWidth-1:4]} * {13'd0, HourRecip};
   assign hour_mul  = {12'd0, hour_ff} * SecsPerHour;
   assign min_prod  = {11'd0, rem_ff[11:2]} * {10'd0, MinRecip};
   assign min_mul   = {11'd0, minute_ff} * SecsPerMin;
   assign sec_full  = rem_ff - min_mul;

   assign leap      = leap_year(year_ff);
   assign year_len  = leap ? (PlainYearDays + 9'd1) : PlainYearDays;
   assign month_len = month_days(mon_ff, leap);

   assign status.year_done  = (days_ff < {{(DaysWidth-9){1'b0}}, year_len});
   assign status.month_done = (days_ff < {{(DaysWidth-5){1'b0}}, month_len}) ||
                              (mon_ff >= LastMonth);

   always_comb begin
      epoch_in      = epoch_ff;
      rem_in        = rem_ff;
      days_in       = days_ff;
      year_in       = year_ff;
      mon_in        = mon_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      out_year_in   = out_year_ff;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_hour_in   = out_hour_ff;
      out_minute_in = out_minute_ff;
      out_second_in = out_second_ff;
      if (cmd.load) begin
         epoch_in = req_epoch_seconds;
      end
      if (cmd.day_quo) begin
         days_in = day_prod[50:35];
      end
      if (cmd.day_rem) begin
         rem_in = epoch_ff[RemWidth-1:0] - day_mul[RemWidth-1:0];
      end
      if (cmd.hour_quo) begin
         hour_in = hour_prod[25:21];
      end
      if (cmd.hour_rem) begin
         rem_in = rem_ff - hour_mul;
      end
      if (cmd.min_quo) begin
         minute_in = min_prod[19:14];
      end
      if (cmd.min_rem) begin
         second_in = sec_full[5:0];
         year_in   = BaseYear;
      end
      if (cmd.year_step) begin
         days_in = days_ff - {{(DaysWidth-9){1'b0}}, year_len};
         year_in = year_ff + 12'd1;
      end
      if (cmd.start_month) begin
         mon_in = '0;
      end
      if (cmd.month_step) begin
         days_in = days_ff - {{(DaysWidth-5){1'b0}}, month_len};
         mon_in  = mon_ff + 4'd1;
      end
      if (cmd.load_out) begin
         out_year_in   = year_ff;
         out_month_in  = mon_ff + 4'd1;
         out_day_in    = days_ff[4:0] + 5'd1;
         out_hour_in   = hour_ff;
         out_minute_in = minute_ff;
         out_second_in = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      epoch_ff      <= epoch_in;
      rem_ff        <= rem_in;
      days_ff       <= days_in;
      year_ff       <= year_in;
      mon_ff        <= mon_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      out_year_ff   <= out_year_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_hour_ff   <= out_hour_in;
      out_minute_ff <= out_minute_in;
      out_second_ff <= out_second_in;
   end

   assign rsp_year   = out_year_ff;
   assign rsp_month  = out_month_ff;
   assign rsp_day    = out_day_ff;
   assign rsp_hour   = out_hour_ff;
   assign rsp_minute = out_minute_ff;
   assign rsp_second = out_second_ff;

   `E2CAL_ASSERT_NOW(a_sod_in_range, clock, reset, cmd.hour_quo, rem_ff < SecsPerDay)
   `E2CAL_ASSERT_NOW(a_hour_in_range, clock, reset, cmd.hour_rem, hour_ff < HoursPerDay)
   `E2CAL_ASSERT_NOW(a_year_in_range, clock, reset, cmd.year_step, year_ff < MaxYear)
   `E2CAL_ASSERT_NOW(a_month_in_range, clock, reset, cmd.month_step, mon_ff < LastMonth)

endmodule

// ----- rtl/e2cal_ctrl.sv -----
// controller: sequences the division stages, the year and month walk and the result word
`timescale 1ns / 1ps
`include "epoch_to_calendar_date_time_unit_assert.svh"

module e2cal_ctrl
   import e2cal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DAYQ  = 4'd1;
   localparam logic [3:0] ST_DAYR  = 4'd2;
   localparam logic [3:0] ST_HOURQ = 4'd3;
   localparam logic [3:0] ST_HOURR = 4'd4;
   localparam logic [3:0] ST_MINQ  = 4'd5;
   localparam logic [3:0] ST_MINR  = 4'd6;
   localparam logic [3:0] ST_YEAR  = 4'd7;
   localparam logic [3:0] ST_MONTH = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DAYQ;
            end
         end
         ST_DAYQ: begin
            cmd.day_quo = 1'b1;
            state_in    = ST_DAYR;
         end
         ST_DAYR: begin
            cmd.day_rem = 1'b1;
            state_in    = ST_HOURQ;
         end
         ST_HOURQ: begin
            cmd.hour_quo = 1'b1;
            state_in     = ST_HOURR;
         end
         ST_HOURR: begin
            cmd.hour_rem = 1'b1;
            state_in     = ST_MINQ;
         end
         ST_MINQ: begin
            cmd.min_quo = 1'b1;
            state_in    = ST_MINR;
         end
         ST_MINR: begin
            // second of minute, seed the year
            cmd.min_rem = 1'b1;
            state_in    = ST_YEAR;
         end
         ST_YEAR: begin
            if (status.year_done) begin
               cmd.start_month = 1'b1;
               state_in        = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (!status.month_done) begin
               cmd.month_step = 1'b1;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `E2CAL_ASSERT_NOW(a_load_out_free, clock, reset, cmd.load_out, !rsp_valid_ff || rsp_ready)
   `E2CAL_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_DAYQ)
   `E2CAL_ASSERT_NEXT(a_load_out_valid, clock, reset, cmd.load_out, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

// ----- rtl/epoch_to_calendar_date_time_unit.sv -----
// top level of the epoch seconds to calendar date and time converter
`timescale 1ns / 1ps

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian year, month, day, hour, minute and second, one word in, one word out.
// One item at a time: the states DAYQ, DAYR, HOURQ, HOURR, MINQ and MINR
// split the seconds by reciprocal multiplication (days and seconds of day,
// hour, minute and second), then the year walk takes off one year per cycle
// (up to 136 steps for the year 2106), and the month walk one month per cycle
// (up to 11 steps for December); the longest case is the last day of 2105.
// The result sits in an output register, so a new word is taken while the
// previous result waits to be read; a finished result that finds the output
// register still full waits in the month walk until it is read.
module epoch_to_calendar_date_time_unit
   import e2cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   e2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   e2cal_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

endmodule
